>>> sv/atd_pkg.sv
`default_nettype none

package atd_pkg;

  localparam int SampleBits  = 12;
  localparam int CordicSteps = 16;
  localparam int MaxSteps    = 24;
  localparam int NumSteps    = (CordicSteps < MaxSteps) ? CordicSteps : MaxSteps;
  localparam int StepW       = $clog2(MaxSteps);

  localparam int AngleFrac = 16;
  localparam int AngleW    = 11;
  localparam int AngleMax  = 1800;

  // Horizontal magnitude squared, then scaled so that the root has 8 fraction bits.
  localparam int HsqW       = 2 * SampleBits;
  localparam int RadW       = HsqW + 16;
  localparam int RootW      = RadW / 2;
  localparam int SqrtCycles = (RootW + 1) / 2;
  localparam int SqrtCntW   = $clog2(SqrtCycles);
  localparam int PadW       = 4 * SqrtCycles;
  localparam int RemW       = 2 * SqrtCycles + 3;

  localparam int CordW = RootW + 3;
  localparam int AccW  = AngleFrac + 12;
  localparam int AtanW = 26;

  localparam logic [AtanW-1:0] AtanTab [MaxSteps] = '{
    26'd29491200, 26'd17409672, 26'd9198793, 26'd4669451, 26'd2343786, 26'd1173036,
    26'd586661,   26'd293348,   26'd146676,  26'd73339,   26'd36669,   26'd18335,
    26'd9167,     26'd4584,     26'd2292,    26'd1146,    26'd573,     26'd286,
    26'd143,      26'd72,       26'd36,      26'd18,      26'd9,       26'd4
  };

  localparam logic signed [AccW-1:0] AccQuarter = AccW'(900 * (2 ** AngleFrac));
  localparam logic signed [AccW-1:0] AccHalf    = AccW'(2 ** (AngleFrac - 1));

  localparam int  AddrW     = 3;
  localparam logic RegThresh = 1'b0;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [AngleW-1:0]            angle_t;
  typedef logic [RadW-1:0]              rad_t;
  typedef logic [RootW-1:0]             root_t;

  localparam angle_t ThreshReset = angle_t'(300);

endpackage

`default_nettype wire

>>> sv/atd_isqrt.sv
`default_nettype none

module atd_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  atd_pkg::rad_t radicand_i,
  output logic          done_o,
  output atd_pkg::root_t root_o
);
  import atd_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [SqrtCntW-1:0]     cnt_q;
  logic [PadW-1:0]         rad_q, rad_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic [2*SqrtCycles-1:0] root_q, root_d;

  // Two result bits per cycle, restoring digit by digit.
  always_comb begin
    logic [RemW-1:0] trial;
    rem_d  = rem_q;
    root_d = root_q;
    rad_d  = rad_q;
    trial  = '0;
    for (int k = 0; k < 2; k++) begin
      rem_d = {rem_d[RemW-3:0], rad_d[PadW-1 -: 2]};
      rad_d = {rad_d[PadW-3:0], 2'b00};
      trial = {1'b0, root_d, 2'b01};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root_d[2*SqrtCycles-2:0], 1'b1};
      end else begin
        root_d = {root_d[2*SqrtCycles-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SqrtCntW'(SqrtCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= PadW'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[RootW-1:0];

endmodule

`default_nettype wire

>>> sv/atd_cordic.sv
`default_nettype none

module atd_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  atd_pkg::sample_t z_i,
  input  atd_pkg::root_t   r_i,
  output logic             done_o,
  output atd_pkg::angle_t  angle_o
);
  import atd_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [StepW-1:0]        cnt_q;
  logic signed [CordW-1:0] x_q, y_q;
  logic signed [AccW-1:0]  acc_q;

  logic signed [CordW-1:0] z_ext, r_ext, dx, dy;
  logic signed [AccW-1:0]  atan_s, acc_r;
  logic [AccW-AngleFrac-1:0] acc_int;

  assign z_ext  = {{(CordW-SampleBits-8){z_i[SampleBits-1]}}, z_i, 8'b0};
  assign r_ext  = {{(CordW-RootW){1'b0}}, r_i};
  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign atan_s = $signed({{(AccW-AtanW){1'b0}}, AtanTab[cnt_q]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepW'(NumSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A vector below the horizontal plane is first turned by a quarter turn.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (z_i[SampleBits-1]) begin
        x_q   <= r_ext;
        y_q   <= -z_ext;
        acc_q <= AccQuarter;
      end else begin
        x_q   <= z_ext;
        y_q   <= r_ext;
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[CordW-1]) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        acc_q <= acc_q + atan_s;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        acc_q <= acc_q - atan_s;
      end
    end
  end

  assign acc_r   = acc_q + AccHalf;
  assign acc_int = acc_r[AccW-1:AngleFrac];

  always_comb begin
    if (acc_r[AccW-1]) begin
      angle_o = '0;
    end else if (acc_int > (AccW-AngleFrac)'(AngleMax)) begin
      angle_o = angle_t'(AngleMax);
    end else begin
      angle_o = acc_int[AngleW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

>>> sv/accel_tilt_detector.sv
// An accepted valid sample passes through the square-root unit (two root bits a cycle),
// then the CORDIC unit (one step a cycle). A failed read or a zero vector skips both
// units and goes from the prepare state straight to the result state.
// The block works on one sample at a time; a new sample is taken while the last
// result still waits in the output register. Reset is asynchronous and active low;
// it clears the tilted flag and the control state and sets the threshold to 300.
`default_nettype none

module accel_tilt_detector (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  atd_pkg::sample_t         accel_x_i,
  input  atd_pkg::sample_t         accel_y_i,
  input  atd_pkg::sample_t         accel_z_i,
  input  logic                     read_ok_i,
  input  logic                     heater_on_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     angle_valid_o,
  output atd_pkg::angle_t          incline_o,
  output logic                     tilted_o,
  output logic                     stop_request_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [atd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import atd_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StPrep   = 3'd1;
  localparam logic [2:0] StSqrt   = 3'd2;
  localparam logic [2:0] StCordic = 3'd3;
  localparam logic [2:0] StFin    = 3'd4;

  logic [2:0] state_q, state_d;
  sample_t    x_q, y_q, z_q;
  logic       heat_q, item_ok_q;
  angle_t     angle_q;
  angle_t     thresh_q;
  logic       tilted_q;

  logic       out_valid_q;
  logic       angle_valid_q, tilted_out_q, stop_q;
  angle_t     incline_q;

  logic                     accept, out_load, sqrt_start, sqrt_done, cordic_start, cordic_done;
  logic signed [HsqW-1:0]   xsq, ysq;
  logic [HsqW-1:0]          hsq;
  root_t                    root;
  angle_t                   cordic_angle;
  logic                     now_tilted;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == StFin) && (!out_valid_q || out_ready_i);

  assign xsq = x_q * x_q;
  assign ysq = y_q * y_q;
  assign hsq = {1'b0, xsq[HsqW-2:0]} + {1'b0, ysq[HsqW-2:0]};

  assign sqrt_start   = (state_q == StPrep) && item_ok_q;
  assign cordic_start = (state_q == StSqrt) && sqrt_done;

  atd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({hsq, 16'b0}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  atd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .z_i     (z_q),
    .r_i     (root),
    .done_o  (cordic_done),
    .angle_o (cordic_angle)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (accept) state_d = StPrep;
      StPrep:   state_d = item_ok_q ? StSqrt : StFin;
      StSqrt:   if (sqrt_done) state_d = StCordic;
      StCordic: if (cordic_done) state_d = StFin;
      StFin:    if (out_load) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  assign now_tilted = (angle_q < thresh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tilted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      thresh_q    <= ThreshReset;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (item_ok_q) begin
          tilted_q <= now_tilted;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (psel && penable && pwrite && pready && (paddr[2] == RegThresh)) begin
        thresh_q <= pwdata[AngleW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q       <= accel_x_i;
      y_q       <= accel_y_i;
      z_q       <= accel_z_i;
      heat_q    <= heater_on_i;
      item_ok_q <= read_ok_i && ((accel_x_i != '0) || (accel_y_i != '0) || (accel_z_i != '0));
    end
    if ((state_q == StPrep) && !item_ok_q) begin
      angle_q <= '0;
    end else if ((state_q == StCordic) && cordic_done) begin
      angle_q <= cordic_angle;
    end
    if (out_load) begin
      angle_valid_q <= item_ok_q;
      incline_q     <= angle_q;
      tilted_out_q  <= item_ok_q ? now_tilted : tilted_q;
      stop_q        <= item_ok_q && now_tilted && !tilted_q && heat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign angle_valid_o  = angle_valid_q;
  assign incline_o      = incline_q;
  assign tilted_o       = tilted_out_q;
  assign stop_request_o = stop_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegThresh) ? {{(32-AngleW){1'b0}}, thresh_q} : 32'd0;

endmodule

`default_nettype wire

>>> sv/atd_checker.sv
`default_nettype none

module atd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input atd_pkg::sample_t          accel_x_i,
  input atd_pkg::sample_t          accel_y_i,
  input atd_pkg::sample_t          accel_z_i,
  input logic                      read_ok_i,
  input logic                      heater_on_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      angle_valid_o,
  input atd_pkg::angle_t           incline_o,
  input logic                      tilted_o,
  input logic                      stop_request_o,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [atd_pkg::AddrW-1:0] paddr,
  input logic [31:0]               pwdata,
  input logic [31:0]               prdata,
  input logic                      pready
);
  import atd_pkg::*;

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(incline_o)
      && $stable(tilted_o) && $stable(stop_request_o) && $stable(angle_valid_o))
    else $error("Result changed while stalled.");

  // The block works on one sample at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input taken again while busy.");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_request_o |-> tilted_o && angle_valid_o)
    else $error("Stop request without a valid tilted sample.");

  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !angle_valid_o |-> (incline_o == '0) && !stop_request_o)
    else $error("Invalid sample carries an angle or a stop request.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && angle_valid_o |-> incline_o <= angle_t'(AngleMax))
    else $error("Angle out of range.");

endmodule

bind accel_tilt_detector atd_checker u_atd_checker (.*);

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
  import atd_pkg::*;

  localparam int CordicIters   = 16;
  localparam int AngleFracBits = 16;
  localparam int AngleTop      = 1800;
  localparam int DrainCycles   = 40;
  localparam int PhaseItems    = 200;
  localparam logic [AddrW-1:0] ThreshAddr = AddrW'(4 * int'(RegThresh));

  localparam longint AtanStep [24] = '{
    29491200, 17409672, 9198793, 4669451, 2343786, 1173036,
    586661, 293348, 146676, 73339, 36669, 18335,
    9167, 4584, 2292, 1146, 573, 286,
    143, 72, 36, 18, 9, 4
  };

  typedef struct packed {
    logic   angle_valid;
    angle_t incline;
    logic   tilted;
    logic   stop_request;
  } tilt_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  sample_t     accel_x_i;
  sample_t     accel_y_i;
  sample_t     accel_z_i;
  logic        read_ok_i;
  logic        heater_on_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        angle_valid_o;
  angle_t      incline_o;
  logic        tilted_o;
  logic        stop_request_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  angle_t       thresh_model;
  logic         tilted_model;
  tilt_result_t pending_results[$];
  int           errors;
  int           gap_odds;
  int           stall_odds;

  accel_tilt_detector DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .read_ok_i      (read_ok_i),
    .heater_on_i    (heater_on_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .angle_valid_o  (angle_valid_o),
    .incline_o      (incline_o),
    .tilted_o       (tilted_o),
    .stop_request_o (stop_request_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic angle_t angle_from_z(sample_t x, sample_t y, sample_t z);
    longint sx, sy, sz, cx, cy, tmp, dx, dy, acc;
    longint unsigned hsq;
    sx = x;
    sy = y;
    sz = z;
    hsq = longint'(sx * sx + sy * sy);
    cx = sz * 256;
    cy = longint'(root_floor(hsq << 16));
    acc = 0;
    if (cx < 0) begin
      tmp = cx;
      cx = cy;
      cy = -tmp;
      acc = longint'(900) << AngleFracBits;
    end
    for (int i = 0; i < CordicIters; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        acc += AtanStep[i];
      end else begin
        cx -= dx;
        cy += dy;
        acc -= AtanStep[i];
      end
    end
    acc += longint'(1) << (AngleFracBits - 1);
    if (acc < 0) return '0;
    acc = acc >>> AngleFracBits;
    if (acc > AngleTop) return angle_t'(AngleTop);
    return angle_t'(acc);
  endfunction

  function automatic tilt_result_t judge_sample(sample_t x, sample_t y, sample_t z,
                                                logic ok, logic heat);
    tilt_result_t r;
    logic now;
    r = '0;
    r.angle_valid = ok && (x != 0 || y != 0 || z != 0);
    if (r.angle_valid) begin
      r.incline = angle_from_z(x, y, z);
      now = r.incline < thresh_model;
      r.stop_request = now && !tilted_model && heat;
      tilted_model = now;
    end
    r.tilted = tilted_model;
    return r;
  endfunction

  function automatic sample_t spread(int s);
    return sample_t'(int'($urandom_range(0, 2 * s)) - s);
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic send_sample(sample_t x, sample_t y, sample_t z, logic ok, logic heat);
    if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk_i);
    end
    @(negedge clk_i);
    accel_x_i   <= x;
    accel_y_i   <= y;
    accel_z_i   <= z;
    read_ok_i   <= ok;
    heater_on_i <= heat;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(judge_sample(x, y, z, ok, heat));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Runs a read transaction on the threshold register and checks the value.
  task automatic read_threshold();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ThreshAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {21'b0, thresh_model}) begin
      note_mismatch("threshold readback", int'(thresh_model), int'(prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(logic [31:0] value);
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ThreshAddr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    thresh_model = angle_t'(value[AngleW-1:0]);
    read_threshold();
  endtask

  task automatic random_sample();
    int pick;
    int span;
    sample_t x, y, z;
    logic ok, heat;
    pick = $urandom_range(0, 99);
    ok   = 1'b1;
    heat = $urandom_range(0, 1);
    x = sample_t'($urandom());
    y = sample_t'($urandom());
    z = sample_t'($urandom());
    if (pick < 8) begin
      ok = 1'b0;
    end else if (pick < 12) begin
      x = '0;
      y = '0;
      z = '0;
    end else if (pick < 65) begin
      z = sample_t'($urandom_range(1, 2047));
      span = $urandom_range(0, int'(z));
      x = spread(span);
      y = spread(span);
      if ($urandom_range(0, 3) == 0) z = -z;
    end else if (pick < 80) begin
      x = spread(8);
      y = spread(8);
      z = spread(8);
    end
    send_sample(x, y, z, ok, heat);
  endtask

  task automatic test_reset_state();
    read_threshold();
    send_sample(12'sd0, 12'sd0, 12'sd2047, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd2047, 1'b1, 1'b1);
    send_sample(12'sd2047, 12'sd0, 12'sd0, 1'b1, 1'b1);
    send_sample(12'sd1024, 12'sd0, 12'sd1774, 1'b1, 1'b0);
    send_sample(12'sd0, 12'sd0, 12'sd1, 1'b1, 1'b0);
  endtask

  task automatic test_extreme_axes();
    gap_odds   = 20;
    stall_odds = 20;
    send_sample(-12'sd2048, 12'sd0, 12'sd0, 1'b1, 1'b1);
    send_sample(12'sd0, -12'sd2048, 12'sd0, 1'b1, 1'b0);
    send_sample(12'sd0, 12'sd2047, 12'sd0, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd0, -12'sd2048, 1'b1, 1'b0);
    send_sample(-12'sd2048, -12'sd2048, -12'sd2048, 1'b1, 1'b1);
    send_sample(12'sd2047, 12'sd2047, 12'sd2047, 1'b1, 1'b0);
    send_sample(12'sd2047, -12'sd2048, 12'sd1, 1'b1, 1'b1);
    send_sample(12'sd1, 12'sd0, 12'sd0, 1'b1, 1'b0);
    send_sample(-12'sd1, -12'sd1, 12'sd1, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd0, -12'sd1, 1'b1, 1'b0);
  endtask

  task automatic test_special_cases();
    send_sample(12'sd0, 12'sd0, 12'sd2047, 1'b1, 1'b0);
    send_sample(12'sd2047, 12'sd2047, 12'sd2047, 1'b0, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd0, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd0, 1'b0, 1'b0);
    send_sample(-12'sd2048, 12'sd0, 12'sd0, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd2047, 1'b1, 1'b1);
  endtask

  task automatic test_threshold_limits();
    set_threshold(32'd0);
    send_sample(12'sd0, 12'sd0, 12'sd2047, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd0, -12'sd2048, 1'b1, 1'b1);
    set_threshold(32'd1800);
    send_sample(12'sd0, 12'sd0, -12'sd2048, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd5, -12'sd2047, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd2047, 1'b1, 1'b1);
    set_threshold(32'hFFFF_FFFF);
    send_sample(12'sd0, 12'sd0, -12'sd2048, 1'b1, 1'b1);
    send_sample(-12'sd2048, -12'sd2048, -12'sd2048, 1'b1, 1'b1);
  endtask

  task automatic test_random_phases();
    int gap_by_phase [6];
    int stall_by_phase [6];
    logic [31:0] thr;
    gap_by_phase   = '{25, 0, 10, 40, 5, 0};
    stall_by_phase = '{25, 0, 40, 10, 3, 0};
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: thr = 32'd300;
        1: thr = $urandom_range(0, 1800);
        2: thr = 32'd1800;
        3: thr = $urandom_range(1801, 2047);
        4: thr = ($urandom() << AngleW) | $urandom_range(0, 2047);
        default: thr = 32'd900;
      endcase
      set_threshold(thr);
      gap_odds   = gap_by_phase[p];
      stall_odds = stall_by_phase[p];
      repeat (PhaseItems) random_sample();
    end
  endtask

  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tilt_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending, angle", 0, int'(incline_o));
      end else begin
        want = pending_results.pop_front();
        if (angle_valid_o !== want.angle_valid) begin
          note_mismatch("angle_valid", int'(want.angle_valid), int'(angle_valid_o));
        end
        if (incline_o !== want.incline) begin
          note_mismatch("incline", int'(want.incline), int'(incline_o));
        end
        if (tilted_o !== want.tilted) begin
          note_mismatch("tilted", int'(want.tilted), int'(tilted_o));
        end
        if (stop_request_o !== want.stop_request) begin
          note_mismatch("stop_request", int'(want.stop_request), int'(stop_request_o));
        end
      end
    end
  end

  initial begin
    errors       = 0;
    gap_odds     = 0;
    stall_odds   = 0;
    thresh_model = ThreshReset;
    tilted_model = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    accel_x_i    = '0;
    accel_y_i    = '0;
    accel_z_i    = '0;
    read_ok_i    = 1'b0;
    heater_on_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_extreme_axes();
    test_special_cases();
    test_threshold_limits();
    test_random_phases();
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/atd_pkg.sv
sv/atd_isqrt.sv
sv/atd_cordic.sv
sv/accel_tilt_detector.sv
sv/atd_checker.sv
tb/tb.sv
